// ===== design/toc_pkg.sv =====
// ----------------------------------------------------------------------------
// toc_pkg
// shared constants, types and command structs of the topological order check
// ----------------------------------------------------------------------------
package toc_pkg;

    localparam int NUM_NODES = 26;
    localparam int LETTER_W  = 5;
    localparam int IDX_W     = $clog2(NUM_NODES);
    localparam int CNT_W     = $clog2(NUM_NODES + 1);

    typedef logic [IDX_W-1:0]     idx_t;
    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [NUM_NODES-1:0] row_t;
    typedef logic [CNT_W-1:0]     deg_t;

    typedef struct packed {
        logic wr_en;
        idx_t wr_row;
        idx_t wr_col;
        logic clr_all;
        logic rd_en;
        idx_t rd_addr;
    } adj_cmd_t;

    typedef struct packed {
        logic wr_en;
        idx_t wr_addr;
        idx_t wr_data;
        logic rd_en;
        idx_t rd_addr;
    } queue_cmd_t;

    typedef struct packed {
        logic strobe;
        idx_t pos;
        logic valid;
        logic complete;
        logic uniq;
        logic last;
    } res_t;

endpackage

// ===== design/toc_adj_mem.sv =====
// ----------------------------------------------------------------------------
// toc_adj_mem
// adjacency bit matrix, one row per source node, with per-row valid bits
// ----------------------------------------------------------------------------
module toc_adj_mem (
    input  logic              clk,
    input  logic              rst_n,
    input  toc_pkg::adj_cmd_t cmd,
    output toc_pkg::row_t     rd_data
);
    import toc_pkg::*;

    row_t mem [NUM_NODES];
    row_t row_valid_reg;
    row_t row_valid_next;
    row_t rd_q;
    logic rd_vld_reg;

    always_comb
    begin
        row_valid_next = row_valid_reg;
        if (cmd.clr_all)
        begin
            row_valid_next = '0;
        end
        else if (cmd.wr_en)
        begin
            row_valid_next[cmd.wr_row] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_valid_reg <= '0;
            rd_vld_reg    <= 1'b0;
        end
        else
        begin
            row_valid_reg <= row_valid_next;
            if (cmd.rd_en)
            begin
                rd_vld_reg <= row_valid_reg[cmd.rd_addr];
            end
        end
    end

    // an invalid row is rewritten whole, so stale bits never survive
    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            if (row_valid_reg[cmd.wr_row])
            begin
                mem[cmd.wr_row][cmd.wr_col] <= 1'b1;
            end
            else
            begin
                mem[cmd.wr_row] <= row_t'(1) << cmd.wr_col;
            end
        end
        if (cmd.rd_en)
        begin
            rd_q <= mem[cmd.rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_q : '0;

endmodule

// ===== design/toc_queue_mem.sv =====
// ----------------------------------------------------------------------------
// toc_queue_mem
// ready queue storage; after a run it holds the order in rank sequence
// ----------------------------------------------------------------------------
module toc_queue_mem (
    input  logic                clk,
    input  toc_pkg::queue_cmd_t cmd,
    output toc_pkg::idx_t       rd_data
);
    import toc_pkg::*;

    idx_t mem [NUM_NODES];

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            mem[cmd.wr_addr] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data <= mem[cmd.rd_addr];
        end
    end

endmodule

// ===== design/toc_seq.sv =====
// ----------------------------------------------------------------------------
// toc_seq
// sequencer: edge loading, in-degree pass, queue push/pop and result drain
// ----------------------------------------------------------------------------
module toc_seq (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [4:0]           from_letter,
    input  logic [4:0]           to_letter,
    input  logic                 edge_valid,
    input  logic                 last,
    input  toc_pkg::row_t        adj_rd,
    input  toc_pkg::idx_t        q_rd,
    output logic                 busy,
    output toc_pkg::adj_cmd_t    adj_cmd,
    output toc_pkg::queue_cmd_t  q_cmd,
    output toc_pkg::res_t        res
);
    import toc_pkg::*;

    typedef enum logic [7:0] {
        ST_IDLE = 8'b0000_0001,
        ST_DEG  = 8'b0000_0010,
        ST_MASK = 8'b0000_0100,
        ST_PUSH = 8'b0000_1000,
        ST_POP  = 8'b0001_0000,
        ST_POPW = 8'b0010_0000,
        ST_UPD  = 8'b0100_0000,
        ST_OUT  = 8'b1000_0000
    } state_t;

    state_t state_reg, state_next;
    cnt_t   cnt_reg, cnt_next;
    logic   acc_vld_reg, acc_vld_next;
    deg_t   indeg_reg [NUM_NODES];
    deg_t   indeg_next [NUM_NODES];
    row_t   pending_reg, pending_next;
    cnt_t   head_reg, head_next;
    cnt_t   tail_reg, tail_next;
    logic   unique_reg, unique_next;
    logic   out_vld_reg, out_vld_next;
    idx_t   out_pos_reg, out_pos_next;

    logic   accept;
    logic   from_ok;
    logic   to_ok;
    row_t   low_oh;
    idx_t   low_idx;

    assign busy   = (state_reg != ST_IDLE) || out_vld_reg;
    assign accept = start && !busy;

    assign from_ok = {1'b0, from_letter} < (LETTER_W + 1)'(NUM_NODES);
    assign to_ok   = {1'b0, to_letter} < (LETTER_W + 1)'(NUM_NODES);

    // lowest pending node goes first
    assign low_oh = pending_reg & (~pending_reg + row_t'(1));

    always_comb
    begin
        low_idx = '0;
        for (int i = 0; i < NUM_NODES; i++)
        begin
            if (low_oh[i])
            begin
                low_idx = low_idx | idx_t'(i);
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        acc_vld_next = 1'b0;
        indeg_next   = indeg_reg;
        pending_next = pending_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        unique_next  = unique_reg;
        out_vld_next = 1'b0;
        out_pos_next = out_pos_reg;
        adj_cmd      = '0;
        q_cmd        = '0;

        case (state_reg)
            ST_IDLE:
            begin
                adj_cmd.wr_en  = accept && edge_valid && from_ok && to_ok;
                adj_cmd.wr_row = from_letter[IDX_W-1:0];
                adj_cmd.wr_col = to_letter[IDX_W-1:0];
                if (accept && last)
                begin
                    state_next  = ST_DEG;
                    cnt_next    = '0;
                    head_next   = '0;
                    tail_next   = '0;
                    unique_next = 1'b1;
                    for (int v = 0; v < NUM_NODES; v++)
                    begin
                        indeg_next[v] = '0;
                    end
                end
            end
            ST_DEG:
            begin
                if (acc_vld_reg)
                begin
                    for (int v = 0; v < NUM_NODES; v++)
                    begin
                        indeg_next[v] = indeg_reg[v] + deg_t'(adj_rd[v]);
                    end
                end
                if (cnt_reg == cnt_t'(NUM_NODES))
                begin
                    state_next = ST_MASK;
                end
                else
                begin
                    adj_cmd.rd_en   = 1'b1;
                    adj_cmd.rd_addr = cnt_reg[IDX_W-1:0];
                    acc_vld_next    = 1'b1;
                    cnt_next        = cnt_reg + cnt_t'(1);
                end
            end
            ST_MASK:
            begin
                for (int v = 0; v < NUM_NODES; v++)
                begin
                    pending_next[v] = (indeg_reg[v] == '0);
                end
                state_next = ST_PUSH;
            end
            ST_PUSH:
            begin
                if (pending_reg != '0)
                begin
                    q_cmd.wr_en   = 1'b1;
                    q_cmd.wr_addr = tail_reg[IDX_W-1:0];
                    q_cmd.wr_data = low_idx;
                    tail_next     = tail_reg + cnt_t'(1);
                    pending_next  = pending_reg & ~low_oh;
                end
                else if (head_reg == tail_reg)
                begin
                    state_next = ST_OUT;
                    cnt_next   = '0;
                end
                else
                begin
                    state_next = ST_POP;
                end
            end
            ST_POP:
            begin
                q_cmd.rd_en   = 1'b1;
                q_cmd.rd_addr = head_reg[IDX_W-1:0];
                if ((tail_reg - head_reg) > cnt_t'(1))
                begin
                    unique_next = 1'b0;
                end
                head_next  = head_reg + cnt_t'(1);
                state_next = ST_POPW;
            end
            ST_POPW:
            begin
                adj_cmd.rd_en   = 1'b1;
                adj_cmd.rd_addr = q_rd;
                state_next      = ST_UPD;
            end
            ST_UPD:
            begin
                for (int v = 0; v < NUM_NODES; v++)
                begin
                    if (adj_rd[v] && (indeg_reg[v] != '0))
                    begin
                        indeg_next[v] = indeg_reg[v] - deg_t'(1);
                        if (indeg_reg[v] == deg_t'(1))
                        begin
                            pending_next[v] = 1'b1;
                        end
                    end
                end
                state_next = ST_PUSH;
            end
            ST_OUT:
            begin
                q_cmd.rd_en   = 1'b1;
                q_cmd.rd_addr = cnt_reg[IDX_W-1:0];
                out_vld_next  = 1'b1;
                out_pos_next  = cnt_reg[IDX_W-1:0];
                cnt_next      = cnt_reg + cnt_t'(1);
                if (cnt_reg == cnt_t'(NUM_NODES - 1))
                begin
                    adj_cmd.clr_all = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            cnt_reg     <= '0;
            acc_vld_reg <= 1'b0;
            pending_reg <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            unique_reg  <= 1'b1;
            out_vld_reg <= 1'b0;
            out_pos_reg <= '0;
            for (int v = 0; v < NUM_NODES; v++)
            begin
                indeg_reg[v] <= '0;
            end
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            acc_vld_reg <= acc_vld_next;
            pending_reg <= pending_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            unique_reg  <= unique_next;
            out_vld_reg <= out_vld_next;
            out_pos_reg <= out_pos_next;
            indeg_reg   <= indeg_next;
        end
    end

    assign res.strobe   = out_vld_reg;
    assign res.pos      = out_pos_reg;
    assign res.valid    = cnt_t'(out_pos_reg) < tail_reg;
    assign res.complete = tail_reg == cnt_t'(NUM_NODES);
    assign res.uniq     = unique_reg;
    assign res.last     = out_vld_reg && (out_pos_reg == idx_t'(NUM_NODES - 1));

endmodule

// ===== design/topological_order_unique_check.sv =====
// ----------------------------------------------------------------------------
// topological_order_unique_check
// loads precedence edges between letters and emits their topological order
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; an item carrying an
// edge with in-range letters is written into the adjacency matrix in that
// cycle, so edges load at one item per clock. The item marked last starts a
// run: a pass over the matrix rows builds the in-degrees, then each ordered
// node takes a queue write, queue check, queue read, row read and in-degree
// update, and NUM_NODES results follow back to back on strobe, which the
// receiver cannot hold off. The length of a run is set by the single read
// port of the matrix and of the ready queue. The matrix is empty again after
// each run.
module topological_order_unique_check (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       start,
    output logic       busy,
    input  logic [4:0] from_letter,
    input  logic [4:0] to_letter,
    input  logic       edge_valid,
    input  logic       last,
    output logic       strobe,
    output logic [4:0] position,
    output logic [4:0] letter,
    output logic       letter_valid,
    output logic       complete,
    output logic       unique_res,
    output logic       last_result
);
    import toc_pkg::*;

    adj_cmd_t   adj_cmd;
    queue_cmd_t q_cmd;
    row_t       adj_rd;
    idx_t       q_rd;
    res_t       res;

    toc_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .from_letter (from_letter),
        .to_letter   (to_letter),
        .edge_valid  (edge_valid),
        .last        (last),
        .adj_rd      (adj_rd),
        .q_rd        (q_rd),
        .busy        (busy),
        .adj_cmd     (adj_cmd),
        .q_cmd       (q_cmd),
        .res         (res)
    );

    toc_adj_mem u_adj_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (adj_cmd),
        .rd_data (adj_rd)
    );

    toc_queue_mem u_queue_mem (
        .clk     (clk),
        .cmd     (q_cmd),
        .rd_data (q_rd)
    );

    assign strobe       = res.strobe;
    assign position     = LETTER_W'(res.pos);
    assign letter       = res.valid ? LETTER_W'(q_rd) : '0;
    assign letter_valid = res.valid;
    assign complete     = res.complete;
    assign unique_res   = res.uniq;
    assign last_result  = res.last;

    // a run starts right after the last item
    a_run_starts: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && last |=> busy)
        else $error("run did not start after last item");

    a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> busy)
        else $error("result while not busy");

    // results of a run come out without gaps
    a_contiguous: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && !last_result |=> strobe)
        else $error("gap in result stream");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        last_result |-> strobe && position == LETTER_W'(NUM_NODES - 1))
        else $error("final result flag at wrong rank");

    a_complete_valid: assert property (@(posedge clk) disable iff (!rst_n)
        strobe && complete |-> letter_valid)
        else $error("complete order has an empty rank");

endmodule

// ===== tb/sv/tb_topological_order_unique_check.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_topological_order_unique_check
// self-checking testbench of the letter topological order check
// ----------------------------------------------------------------------------
// Edges are sent as single items. A scoreboard keeps its own copy of the
// adjacency matrix and, on every item marked last, runs a queue-based
// topological sort to predict the rank-by-rank results. Each strobed result
// is compared with the oldest prediction. A short directed part covers
// empty runs, out-of-range letters, self edges, duplicates and cycles.
// Random runs follow: full chains with extra forward edges, partial orders,
// orders broken by a backward or self edge, and noise items. The sender
// works in bursts with random gaps.
// ----------------------------------------------------------------------------
import toc_pkg::*;

typedef struct packed {
    logic [4:0] from_letter;
    logic [4:0] to_letter;
    logic       edge_valid;
    logic       last;
} letter_item_t;

typedef struct packed {
    logic [4:0] position;
    logic [4:0] letter;
    logic       letter_valid;
    logic       complete;
    logic       unique_res;
    logic       last_result;
} rank_result_t;

class order_scoreboard;
    row_t         adj_rows [NUM_NODES];
    rank_result_t expected_ranks [$];
    int           mismatches;
    int           results_checked;
    int           runs_total;
    int           runs_complete;
    int           runs_unique;
    int           runs_broken;

    function new();
        foreach (adj_rows[i])
            adj_rows[i] = '0;
        mismatches      = 0;
        results_checked = 0;
        runs_total      = 0;
        runs_complete   = 0;
        runs_unique     = 0;
        runs_broken     = 0;
    endfunction

    function void predict_order();
        int           in_deg [NUM_NODES];
        int           ready [$];
        int           order [$];
        int           u;
        logic         uniq;
        logic         full;
        rank_result_t r;
        uniq = 1'b1;
        for (int v = 0; v < NUM_NODES; v++)
        begin
            in_deg[v] = 0;
            for (int w = 0; w < NUM_NODES; w++)
                if (adj_rows[w][v])
                    in_deg[v]++;
        end
        for (int v = 0; v < NUM_NODES; v++)
            if (in_deg[v] == 0)
                ready = {ready, v};
        while (ready.size() > 0)
        begin
            if (ready.size() > 1)
                uniq = 1'b0;
            u = ready.pop_front();
            order = {order, u};
            for (int v = 0; v < NUM_NODES; v++)
                if (adj_rows[u][v] && in_deg[v] > 0)
                begin
                    in_deg[v]--;
                    if (in_deg[v] == 0)
                        ready = {ready, v};
                end
        end
        full = (order.size() == NUM_NODES);
        for (int p = 0; p < NUM_NODES; p++)
        begin
            r.position     = p[4:0];
            r.letter       = (p < order.size()) ? order[p][4:0] : 5'd0;
            r.letter_valid = (p < order.size());
            r.complete     = full;
            r.unique_res   = uniq;
            r.last_result  = (p == NUM_NODES - 1);
            expected_ranks = {expected_ranks, r};
        end
        runs_total++;
        if (full)
            runs_complete++;
        else
            runs_broken++;
        if (uniq)
            runs_unique++;
        foreach (adj_rows[i])
            adj_rows[i] = '0;
    endfunction

    function void note_item(letter_item_t it);
        if (it.edge_valid && it.from_letter < NUM_NODES && it.to_letter < NUM_NODES)
            adj_rows[it.from_letter][it.to_letter] = 1'b1;
        if (it.last)
            predict_order();
    endfunction

    function void check_result(rank_result_t got);
        rank_result_t exp_r;
        if (expected_ranks.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: pos %0d letter %0d valid %0b",
                         got.position, got.letter, got.letter_valid);
            return;
        end
        exp_r = expected_ranks.pop_front();
        results_checked++;
        if (got !== exp_r)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display({"mismatch: expected pos %0d letter %0d v%0b c%0b u%0b l%0b, ",
                          "got pos %0d letter %0d v%0b c%0b u%0b l%0b"},
                         exp_r.position, exp_r.letter, exp_r.letter_valid, exp_r.complete,
                         exp_r.unique_res, exp_r.last_result,
                         got.position, got.letter, got.letter_valid, got.complete,
                         got.unique_res, got.last_result);
        end
    endfunction

    function int pending();
        return expected_ranks.size();
    endfunction
endclass

module tb_topological_order_unique_check;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic [4:0] from_letter = 5'd0;
    logic [4:0] to_letter = 5'd0;
    logic       edge_valid = 1'b0;
    logic       last = 1'b0;
    logic       busy;
    logic       strobe;
    logic [4:0] position;
    logic [4:0] letter;
    logic       letter_valid;
    logic       complete;
    logic       unique_res;
    logic       last_result;

    order_scoreboard sb = new();
    int              items_sent = 0;
    int              burst_left = 0;
    int              drain_guard = 0;

    topological_order_unique_check dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .from_letter  (from_letter),
        .to_letter    (to_letter),
        .edge_valid   (edge_valid),
        .last         (last),
        .strobe       (strobe),
        .position     (position),
        .letter       (letter),
        .letter_valid (letter_valid),
        .complete     (complete),
        .unique_res   (unique_res),
        .last_result  (last_result)
    );

    always #1 clk = ~clk;

    // accepted items and strobed results, sampled before the edge updates
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (start && !busy)
                sb.note_item('{from_letter, to_letter, edge_valid, last});
            if (strobe)
                sb.check_result('{position, letter, letter_valid, complete,
                                  unique_res, last_result});
        end
    end

    initial
    begin
        #500000;
        $display("status: fail");
        $finish;
    end

    function automatic letter_item_t mk_item(int f, int t, bit v, bit l);
        letter_item_t it;
        it.from_letter = f[4:0];
        it.to_letter   = t[4:0];
        it.edge_valid  = v;
        it.last        = l;
        return it;
    endfunction

    task automatic send_item(letter_item_t it);
        start       <= 1'b1;
        from_letter <= it.from_letter;
        to_letter   <= it.to_letter;
        edge_valid  <= it.edge_valid;
        last        <= it.last;
        do
            @(posedge clk);
        while (busy);
        items_sent++;
        if (burst_left > 0)
            burst_left--;
        else
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 6))
                @(posedge clk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 8);
        end
    endtask

    task automatic send_run(letter_item_t run_items [$]);
        foreach (run_items[i])
            send_item(run_items[i]);
    endtask

    // one random run; the final item carries last
    task automatic random_run();
        letter_item_t run_items [$];
        letter_item_t tmp;
        int           perm [NUM_NODES];
        int           kind;
        int           n;
        int           a;
        int           b;
        int           j;
        int           sw;
        kind = $urandom_range(0, 9);
        for (int i = 0; i < NUM_NODES; i++)
            perm[i] = i;
        for (int i = NUM_NODES - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            sw = perm[i];
            perm[i] = perm[j];
            perm[j] = sw;
        end
        if (kind <= 3 || kind == 9)
        begin
            // full chain, plus forward edges that keep the order unique
            for (int i = 0; i < NUM_NODES - 1; i++)
                run_items = {run_items, mk_item(perm[i], perm[i + 1], 1'b1, 1'b0)};
            n = $urandom_range(0, 6);
            for (int i = 0; i < n; i++)
            begin
                a = $urandom_range(0, NUM_NODES - 2);
                b = $urandom_range(a + 1, NUM_NODES - 1);
                run_items = {run_items, mk_item(perm[a], perm[b], 1'b1, 1'b0)};
            end
            if (kind == 9)
            begin
                // close the chain into a loop or cut it with a backward edge
                a = $urandom_range(0, NUM_NODES - 1);
                b = $urandom_range(0, a);
                run_items = {run_items, mk_item(perm[a], perm[b], 1'b1, 1'b0)};
            end
        end
        else if (kind <= 7)
        begin
            n = $urandom_range(1, 20);
            for (int i = 0; i < n; i++)
            begin
                a = $urandom_range(0, NUM_NODES - 2);
                b = $urandom_range(a + 1, NUM_NODES - 1);
                run_items = {run_items, mk_item(perm[a], perm[b], 1'b1, 1'b0)};
            end
            if (kind >= 6)
            begin
                a = $urandom_range(0, NUM_NODES - 1);
                b = $urandom_range(0, a);
                run_items = {run_items, mk_item(perm[a], perm[b], 1'b1, 1'b0)};
            end
        end
        else
        begin
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++)
                run_items = {run_items, mk_item($urandom_range(0, 31), $urandom_range(0, 31),
                                                1'($urandom_range(0, 1)), 1'b0)};
        end
        // noise mixed into the run
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 1))
                run_items = {run_items, mk_item($urandom_range(0, 31), $urandom_range(0, 31),
                                                1'b0, 1'b0)};
            else
                run_items = {run_items, mk_item($urandom_range(26, 31), $urandom_range(0, 31),
                                                1'b1, 1'b0)};
        end
        for (int i = run_items.size() - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = run_items[i];
            run_items[i] = run_items[j];
            run_items[j] = tmp;
        end
        if ($urandom_range(0, 4) == 0)
            run_items = {run_items, mk_item($urandom_range(0, 31), $urandom_range(0, 31),
                                            1'b0, 1'b1)};
        else
            run_items[run_items.size() - 1].last = 1'b1;
        send_run(run_items);
    endtask

    initial
    begin
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty run: every letter free, queue holds all of them
        send_run('{mk_item(0, 0, 1'b0, 1'b1)});
        // out-of-range letters and an empty item are dropped
        send_run('{mk_item(31, 0, 1'b1, 1'b0), mk_item(0, 31, 1'b1, 1'b0),
                   mk_item(26, 26, 1'b1, 1'b0), mk_item(31, 31, 1'b1, 1'b0),
                   mk_item(5, 6, 1'b0, 1'b0), mk_item(0, 25, 1'b1, 1'b1)});
        // self edge keeps its letter out of the order
        send_run('{mk_item(25, 0, 1'b1, 1'b0), mk_item(5, 5, 1'b1, 1'b0),
                   mk_item(0, 0, 1'b0, 1'b1)});
        // two-letter cycle and a repeated edge
        send_run('{mk_item(1, 2, 1'b1, 1'b0), mk_item(2, 1, 1'b1, 1'b0),
                   mk_item(3, 4, 1'b1, 1'b0), mk_item(3, 4, 1'b1, 1'b0),
                   mk_item(3, 4, 1'b1, 1'b1)});

        while (items_sent < 430)
            random_run();
        start <= 1'b0;

        while (sb.pending() != 0 && drain_guard < 100000)
        begin
            @(posedge clk);
            drain_guard++;
        end
        repeat (200)
            @(posedge clk);
        if (sb.pending() != 0)
        begin
            $display("%0d expected results never arrived", sb.pending());
            sb.mismatches++;
        end

        $display("ran %0d items in %0d sorts: %0d complete, %0d with a cycle, %0d unique",
                 items_sent, sb.runs_total, sb.runs_complete, sb.runs_broken,
                 sb.runs_unique);
        $display("checked %0d results, %0d mismatches", sb.results_checked,
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
